>>> hdl/work_stealing_task_dispatcher_macros.svh
// Assertion helpers for the dispatcher
`ifndef WORK_STEALING_TASK_DISPATCHER_MACROS_SVH
`define WORK_STEALING_TASK_DISPATCHER_MACROS_SVH
// Implication checked on every clock, off during reset
`define WSTD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("violation");
// Next-cycle implication
`define WSTD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("violation");
`endif

>>> hdl/wstd_pkg.sv
package wstd_pkg;
   localparam int Workers    = 8;
   localparam int QueueDepth = 256;
   localparam int StealTries = 3;
   localparam int WidW  = $clog2(Workers);
   localparam int WidQ  = $clog2(QueueDepth);
   localparam int WidC  = WidQ + 1;
   localparam int WidT  = $clog2(StealTries + 1);

   localparam logic [1:0] CSR_ACTIVE = 2'd0;
   localparam logic [1:0] CSR_SEED   = 2'd1;
   localparam logic [1:0] CSR_ACCEPT = 2'd2;

   localparam logic [1:0] SRC_LOCAL  = 2'd0;
   localparam logic [1:0] SRC_GLOBAL = 2'd1;
   localparam logic [1:0] SRC_STOLEN = 2'd2;

   localparam logic ACT_SUBMIT = 1'b0;
   localparam logic ACT_GET    = 1'b1;

   typedef struct packed {
      logic        action;
      logic [2:0]  worker_id;
      logic        from_worker;
      logic [31:0] task_handle;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] task_out;
      logic [1:0]  source;
      logic [2:0]  victim;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RNG,
      ST_MOD,
      ST_PICK,
      ST_READ,
      ST_DONE
   } state_type;

   // xorshift 13/17/5
   function automatic logic [31:0] xorshift(input logic [31:0] s);
      logic [31:0] x;
      x = s ^ (s << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction
endpackage

>>> hdl/wstd_front.sv
// Front end: input queue stage with a small two-entry FIFO of requests
module wstd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  wstd_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output wstd_pkg::req_type cmd_data
);
   import wstd_pkg::*;

   req_type    fifo_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       wr_in, rd_in;
   logic [1:0] cnt_in;
   logic       do_push, do_pop;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = fifo_ff[rd_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_ff[wr_ff] <= req_data;
      end
   end
endmodule

>>> hdl/wstd_back.sv
// Back end: deque/global storage, steal sequencer, result FIFO
module wstd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  wstd_pkg::req_type cmd_data,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   output logic              idle,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output wstd_pkg::rsp_type rsp_data
);
   import wstd_pkg::*;

   logic [31:0] dq_mem [Workers*QueueDepth];
   logic [31:0] gl_mem [QueueDepth];
   logic [WidQ-1:0] top_ff [Workers];
   logic [WidC-1:0] cnt_ff [Workers];
   logic [WidQ-1:0] ghead_ff;
   logic [WidC-1:0] gcnt_ff;
   logic [31:0]     rng_ff;
   logic [3:0]      act_ff;
   logic            acc_ff;

   state_type       state_ff, state_in;
   req_type         cur_ff;
   logic [3:0]      n_ff;
   logic [WidT-1:0] try_ff, try_in;
   logic [31:0]     rem_ff, rem_in;
   logic [3:0]      macc_ff, macc_in;
   logic [1:0]      stp_ff, stp_in;
   logic [3:0]      mod_acc;
   logic [WidW-1:0] vic_ff, vic_in;
   logic [1:0]      kind_ff, kind_in;
   logic [31:0]     rd_ff;
   logic [WidQ+WidW-1:0] raddr;
   logic            use_glb;

   rsp_type rq_ff [2];
   logic    rqw_ff, rqr_ff;
   logic [1:0] rqc_ff;
   logic    rq_push;
   rsp_type rq_in;

   logic [WidW-1:0] self_w;
   logic member;
   logic [WidC-1:0] own_cnt;
   logic [WidQ-1:0] own_top;

   localparam logic [1:0] K_NONE = 2'd0;
   localparam logic [1:0] K_OWN  = 2'd1;
   localparam logic [1:0] K_GLB  = 2'd2;
   localparam logic [1:0] K_STL  = 2'd3;

   assign self_w  = cur_ff.worker_id[WidW-1:0];
   assign member  = {1'b0, cur_ff.worker_id} < n_ff;
   assign own_cnt = cnt_ff[self_w];
   assign own_top = top_ff[self_w];
   assign idle    = (state_ff == ST_IDLE) && !cmd_valid && (rqc_ff == 2'd0);
   assign cmd_take = (state_ff == ST_IDLE) && (rqc_ff != 2'd2);

   // result fifo
   assign rsp_empty = (rqc_ff == 2'd0);
   assign rsp_data  = rq_ff[rqr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rqw_ff <= 1'b0;
         rqr_ff <= 1'b0;
         rqc_ff <= 2'd0;
      end else begin
         if (rq_push) rqw_ff <= !rqw_ff;
         if (rsp_pop && !rsp_empty) rqr_ff <= !rqr_ff;
         rqc_ff <= rqc_ff + {1'b0, rq_push} - {1'b0, rsp_pop && !rsp_empty};
      end
   end
   always_ff @(posedge clock) begin
      if (rq_push) rq_ff[rqw_ff] <= rq_in;
   end

   // remainder by n, eight bits per cycle; n <= 8 keeps the partial below 16
   always_comb begin
      mod_acc = macc_ff;
      for (int b = 31; b >= 24; b--) begin
         mod_acc = {mod_acc[2:0], rem_ff[b]};
         if (mod_acc >= n_ff) mod_acc = mod_acc - n_ff;
      end
   end

   // control FSM
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      try_in   = try_ff;
      rem_in   = rem_ff;
      macc_in  = macc_ff;
      stp_in   = stp_ff;
      vic_in   = vic_ff;
      kind_in  = kind_ff;
      rq_push  = 1'b0;
      rq_in    = '0;
      raddr    = '0;
      use_glb  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_take && cmd_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            kind_in  = K_NONE;
            try_in   = '0;
            vic_in   = '0;
            if (cur_ff.action == ACT_SUBMIT) begin
               kind_in = K_NONE;
            end else if (member && own_cnt != '0) begin
               kind_in  = K_OWN;
               state_in = ST_READ;
            end else if (gcnt_ff != '0) begin
               kind_in  = K_GLB;
               state_in = ST_READ;
            end else if (n_ff > 4'd1) begin
               state_in = ST_RNG;
            end
         end
         ST_RNG: begin
            // advance the generator and start the remainder
            rem_in   = xorshift(rng_ff);
            macc_in  = '0;
            stp_in   = '0;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            // four passes over the random value, top byte first
            rem_in  = {rem_ff[23:0], 8'd0};
            macc_in = mod_acc;
            stp_in  = stp_ff + 1'b1;
            if (stp_ff == 2'd3) state_in = ST_PICK;
         end
         ST_PICK: begin
            // macc_ff holds the random value mod n
            vic_in = (macc_ff[WidW-1:0] == self_w) ?
                     ((macc_ff + 4'd1 == n_ff) ? '0 : macc_ff[WidW-1:0] + 1'b1)
                     : macc_ff[WidW-1:0];
            try_in = try_ff + 1'b1;
            if (cnt_ff[vic_in] != '0) begin
               kind_in  = K_STL;
               state_in = ST_READ;
            end else if (try_ff + 1'b1 == WidT'(StealTries)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RNG;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
            rq_push  = 1'b1;
            rq_in.victim = 3'(vic_ff);
            if (cur_ff.action == ACT_SUBMIT) begin
               if (acc_ff && cur_ff.task_handle != '0) begin
                  if (cur_ff.from_worker && member && own_cnt != WidC'(QueueDepth)) begin
                     rq_in.ok = 1'b1;
                     rq_in.source = SRC_LOCAL;
                  end else if (gcnt_ff != WidC'(QueueDepth)) begin
                     rq_in.ok = 1'b1;
                     rq_in.source = SRC_GLOBAL;
                  end
               end
               rq_in.victim = '0;
            end else if (kind_ff != K_NONE) begin
               rq_in.ok       = 1'b1;
               rq_in.task_out = rd_ff;
               rq_in.source   = (kind_ff == K_OWN) ? SRC_LOCAL :
                                (kind_ff == K_GLB) ? SRC_GLOBAL : SRC_STOLEN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // read address for ST_READ
      case (kind_ff)
         K_OWN: raddr = {self_w, WidQ'(own_top + own_cnt[WidQ-1:0] - 1'b1)};
         K_STL: raddr = {vic_ff, top_ff[vic_ff]};
         default: raddr = '0;
      endcase
      use_glb = (kind_ff == K_GLB);
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd_take && cmd_valid) begin
         cur_ff <= cmd_data;
         n_ff   <= (act_ff == 4'd0) ? 4'd1 :
                   (act_ff > 4'(Workers)) ? 4'(Workers) : act_ff;
      end
      try_ff  <= try_in;
      vic_ff  <= vic_in;
      kind_ff <= kind_in;
      rem_ff  <= rem_in;
      macc_ff <= macc_in;
      stp_ff  <= stp_in;
      if (state_ff == ST_READ) begin
         rd_ff <= use_glb ? gl_mem[ghead_ff] : dq_mem[raddr];
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < Workers; w++) begin
            top_ff[w] <= '0;
            cnt_ff[w] <= '0;
         end
         ghead_ff <= '0;
         gcnt_ff  <= '0;
         act_ff   <= 4'd1;
         acc_ff   <= 1'b1;
         rng_ff   <= 32'd1;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_ACTIVE: act_ff <= csr_data[3:0];
               CSR_SEED:   rng_ff <= csr_data;
               CSR_ACCEPT: acc_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (state_ff == ST_RNG) rng_ff <= rem_in;
         if (state_ff == ST_DONE) begin
            if (cur_ff.action == ACT_SUBMIT && rq_in.ok) begin
               if (rq_in.source == SRC_LOCAL) cnt_ff[self_w] <= own_cnt + 1'b1;
               else gcnt_ff <= gcnt_ff + 1'b1;
            end else if (cur_ff.action == ACT_GET) begin
               case (kind_ff)
                  K_OWN: cnt_ff[self_w] <= own_cnt - 1'b1;
                  K_GLB: begin
                     ghead_ff <= ghead_ff + 1'b1;
                     gcnt_ff  <= gcnt_ff - 1'b1;
                  end
                  K_STL: begin
                     top_ff[vic_ff] <= top_ff[vic_ff] + 1'b1;
                     cnt_ff[vic_ff] <= cnt_ff[vic_ff] - 1'b1;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   // store writes
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && cur_ff.action == ACT_SUBMIT && rq_in.ok) begin
         if (rq_in.source == SRC_LOCAL)
            dq_mem[{self_w, WidQ'(own_top + own_cnt[WidQ-1:0])}] <= cur_ff.task_handle;
         else
            gl_mem[WidQ'(ghead_ff + gcnt_ff[WidQ-1:0])] <= cur_ff.task_handle;
      end
   end
endmodule

>>> hdl/work_stealing_task_dispatcher.sv
// Work-stealing task dispatcher.
// Request channel: push/full queue carrying action, worker_id, from_worker and
// task_handle. Response channel: empty/pop queue carrying ok, task_out, source
// and victim, exactly one response per request, in request order.
// CSR channel: csr_valid/csr_ready with index (0 active_workers, 1 random_seed,
// 2 accepting) and data; writes are taken only while the dispatcher is idle.
// A submit passes through decide and done; a local or global get also reads the
// store before done. A get that steals makes up to three attempts, each of which
// advances the generator, takes the remainder by the worker count and picks the
// victim; when all three attempts find nothing, the get responds without a task.
// One request is in the sequencer at a time; it takes the next request only
// after it has queued the response to the last one.
// Reset (synchronous, active high) empties all deques, the global queue and
// both small queues, and restores active_workers=1, seed=1, accepting=1.
// When the receiver stops popping, the two-entry response queue fills, the
// sequencer holds, and the two-entry request queue then raises full.
module work_stealing_task_dispatcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  wstd_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output wstd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import wstd_pkg::*;

   logic    cmd_valid, cmd_take, idle;
   req_type cmd_data;

   assign csr_ready = idle;

   wstd_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   wstd_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .csr_valid(csr_valid && csr_ready), .csr_index, .csr_data, .idle,
      .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule

>>> hdl/wstd_checker.sv
`include "work_stealing_task_dispatcher_macros.svh"
module wstd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input wstd_pkg::rsp_type rsp_data,
   input logic              csr_ready
);
   import wstd_pkg::*;
   `WSTD_ASSERT_IMP(a_fail_zero, clock, reset, !rsp_empty && !rsp_data.ok, rsp_data.task_out == '0 && rsp_data.source == SRC_LOCAL)
   `WSTD_ASSERT_IMP(a_src_range, clock, reset, !rsp_empty, rsp_data.source != 2'd3)
   `WSTD_ASSERT_IMP(a_idle_empty, clock, reset, csr_ready, rsp_empty && !req_full)
   `WSTD_ASSERT_NXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
endmodule

bind work_stealing_task_dispatcher wstd_checker u_chk (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_data, .csr_ready
);
